// ===== design/brf_pkg.sv =====
`default_nettype none

package brf_pkg;

  // command codes
  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_PEEK  = 3'd2;
  localparam logic [2:0] CMD_DROP  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  // width of the byte lane index in one transfer word
  localparam int LANE_IDX_W = 3;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  byte_count;
    logic [63:0] write_bytes;
  } brf_in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] read_bytes;
    logic [8:0]  fill_level;
    logic        is_empty;
  } brf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_READ,
    ST_RD_WAIT,
    ST_RESP
  } brf_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic decide;
    logic wr_step;
    logic rd_issue;
    logic commit;
  } brf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
    logic direct;
    logic is_write;
    logic last;
  } brf_stat_t;

endpackage

`default_nettype wire

// ===== design/brf_ram.sv =====
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/brf_ctrl.sv =====
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire brf_stat_t stat,
  output brf_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  brf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!stat.ok || stat.direct) state_next = ST_RESP;
        else if (stat.is_write)      state_next = ST_WRITE;
        else                         state_next = ST_READ;
      end
      ST_WRITE: begin
        if (stat.last) state_next = ST_RESP;
      end
      ST_READ: begin
        if (stat.last) state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: state_next = ST_RESP;
      ST_RESP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    busy     = 1'b1;
    done     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.commit = stat.ok && stat.direct;
      end
      ST_WRITE: begin
        cmd.wr_step = 1'b1;
        cmd.commit  = stat.last;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
      end
      ST_RD_WAIT: begin
        cmd.commit = 1'b1;
      end
      ST_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // state is committed in the cycle before the result goes out
  a_commit_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit not followed by result");

endmodule

`default_nettype wire

// ===== design/brf_dp.sv =====
`default_nettype none

module brf_dp
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_XFER = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire brf_in_t  request,
  input  wire brf_cmd_t cmd,
  output brf_stat_t     stat,
  output brf_out_t      result
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = CNT_W + 4;
  localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(DEPTH);
  localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(DEPTH - 1);
  localparam logic [3:0]        MAX_N   = 4'(MAX_XFER);

  brf_in_t               req;
  logic [63:0]           wshift;
  logic [63:0]           acc;
  logic [PTR_W-1:0]      walk;
  logic [PTR_W-1:0]      rp;
  logic [PTR_W-1:0]      wp;
  logic [CNT_W-1:0]      count;
  logic [LANE_IDX_W-1:0] k;
  logic [LANE_IDX_W-1:0] ridx;
  logic                  rvalid;
  logic                  ok_q;
  logic                  ok_c;
  logic [7:0]            rdata;
  logic [PTR_W-1:0]      walk_next;
  logic [WIDE_W-1:0]     cnt_w;
  logic [WIDE_W-1:0]     n_w;
  logic [CNT_W+8:0]      cnt_ext;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [3:0] n);
    logic [WIDE_W-1:0] s;
    s = WIDE_W'(p) + WIDE_W'(n);
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[PTR_W-1:0];
  endfunction

  assign cnt_w     = WIDE_W'(count);
  assign n_w       = WIDE_W'(req.byte_count);
  assign walk_next = (walk == LAST_P) ? '0 : walk + PTR_W'(1);

  always_comb begin
    unique case (req.command) inside
      CMD_WRITE:                   ok_c = (req.byte_count <= MAX_N) &&
                                          (cnt_w + n_w <= DEPTH_W);
      CMD_READ, CMD_PEEK, CMD_DROP: ok_c = (req.byte_count <= MAX_N) &&
                                          (cnt_w >= n_w);
      CMD_CLEAR:                   ok_c = 1'b1;
      default:                     ok_c = 1'b0;
    endcase
  end

  assign stat.ok       = ok_c;
  assign stat.direct   = (req.byte_count == 4'd0) || (req.command == CMD_DROP) ||
                         (req.command == CMD_CLEAR);
  assign stat.is_write = (req.command == CMD_WRITE);
  assign stat.last     = ({1'b0, k} + 4'd1) == req.byte_count;

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_step),
    .waddr (walk),
    .wdata (wshift[7:0]),
    .raddr (walk),
    .rdata (rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req    <= request;
      wshift <= request.write_bytes;
    end else if (cmd.wr_step) begin
      wshift <= wshift >> 8;
    end
    if (cmd.decide) begin
      ok_q <= ok_c;
      k    <= '0;
      walk <= stat.is_write ? wp : rp;
    end else if (cmd.wr_step || cmd.rd_issue) begin
      k    <= k + LANE_IDX_W'(1);
      walk <= walk_next;
    end
    ridx <= k;
    if (cmd.decide) begin
      acc <= '0;
    end else if (rvalid) begin
      acc[8*ridx +: 8] <= rdata;
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      rp     <= '0;
      wp     <= '0;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= cmd.rd_issue;
      if (cmd.commit) begin
        unique case (req.command) inside
          CMD_WRITE: begin
            wp    <= ring_add(wp, req.byte_count);
            count <= count + CNT_W'(req.byte_count);
          end
          CMD_READ, CMD_DROP: begin
            rp    <= ring_add(rp, req.byte_count);
            count <= count - CNT_W'(req.byte_count);
          end
          CMD_CLEAR: begin
            rp    <= '0;
            wp    <= '0;
            count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cnt_ext           = {9'b0, count};
  assign result.ok         = ok_q;
  assign result.read_bytes = acc;
  assign result.fill_level = cnt_ext[8:0];
  assign result.is_empty   = (count == '0);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    WIDE_W'(count) <= DEPTH_W)
    else $error("fill count above depth");

  a_mem_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_step || cmd.rd_issue) |-> ok_q)
    else $error("memory access on a failed command");

endmodule

`default_nettype wire

// ===== design/byte_ring_fifo_multi_byte.sv =====
`default_nettype none

// byte ring fifo with multi-byte commands
//
// request channel: a command is taken at the rising edge where start is high
// and busy is low; request carries command, byte_count and write_bytes
// result channel: done is high for exactly one cycle and result holds ok,
// read_bytes, fill_level and is_empty for that cycle; there is no stall
// from the receiver, so the result must be taken in that cycle
// one command is worked at a time; busy stays high until the result is out
// states worked from the accepting edge to the result cycle:
//   write           decide, one write step per byte, result
//   read, peek      decide, one read step per byte, a wait for the registered memory read, result
//   drop, clear, zero length or failed commands   decide, result
// a new command may be taken the cycle after done; the byte-wide ring memory
// moves one byte per cycle while a write or read is worked
// reset clears both pointers and the fill count; the ring contents are not
// cleared and need not be, as only written bytes can ever be read
module byte_ring_fifo_multi_byte
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_XFER = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire brf_in_t request,
  output logic         done,
  output brf_out_t     result
);

  brf_cmd_t  cmd;
  brf_stat_t stat;

  // sequencing of each transfer
  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // pointers, fill count, ring memory and byte assembly
  brf_dp #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ===== sim/byte_ring_fifo_multi_byte_test.sv =====
`default_nettype none

module byte_ring_fifo_multi_byte_test;
  import brf_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RING_DEPTH  = 256;
  localparam int XFER_LIMIT  = 8;
  localparam int RANDOM_CMDS = 300;
  localparam int MAX_GAP     = 14;
  // spare command codes, ignored by the block
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  brf_in_t  request;
  logic     done;
  brf_out_t result;

  byte_ring_fifo_multi_byte #(
    .DEPTH    (RING_DEPTH),
    .MAX_XFER (XFER_LIMIT)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // shadow copy of the ring, kept in step with every accepted command
  logic [7:0] ring_bytes [0:RING_DEPTH-1];
  logic [7:0] ring_rd_ptr;  // 8 bits, so wrap at 256 comes for free
  logic [7:0] ring_wr_ptr;
  logic [8:0] ring_level;

  // replies still owed by the block, oldest first
  brf_out_t replies_due [$];
  int       error_count;
  int       gap_ceiling;  // 0 gives a back-to-back stretch

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // apply one command to the shadow ring and return the reply it should give
  function automatic brf_out_t apply_ring_command(brf_in_t req);
    brf_out_t   reply;
    logic [7:0] ptr;
    int         n;
    int         i;
    logic       len_ok;
    reply  = '0;
    n      = int'(req.byte_count);
    len_ok = (n <= XFER_LIMIT);
    case (req.command) inside
      CMD_WRITE: begin
        if (len_ok && (int'(ring_level) + n <= RING_DEPTH)) begin
          for (i = 0; i < n; i++) begin
            ring_bytes[ring_wr_ptr] = req.write_bytes[8*i +: 8];
            ring_wr_ptr = ring_wr_ptr + 8'd1;
          end
          ring_level = ring_level + 9'(n);
          reply.ok = 1'b1;
        end
      end
      CMD_READ, CMD_PEEK, CMD_DROP: begin
        if (len_ok && (int'(ring_level) >= n)) begin
          ptr = ring_rd_ptr;
          for (i = 0; i < n; i++) begin
            // a drop hands nothing back
            if (req.command != CMD_DROP) reply.read_bytes[8*i +: 8] = ring_bytes[ptr];
            ptr = ptr + 8'd1;
          end
          // peek leaves the read side where it was
          if (req.command != CMD_PEEK) begin
            ring_rd_ptr = ptr;
            ring_level  = ring_level - 9'(n);
          end
          reply.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        // contents stay, only the pointers and the level go back to zero
        ring_rd_ptr = '0;
        ring_wr_ptr = '0;
        ring_level  = '0;
        reply.ok    = 1'b1;
      end
      default: ;  // spare codes change nothing
    endcase
    reply.fill_level = ring_level;
    reply.is_empty   = (ring_level == 9'd0);
    return reply;
  endfunction

  // drop start so that nothing further is taken while the sender waits
  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // one command transfer: optional gap, then hold start until busy is low
  task automatic issue_command(input logic [2:0] cmd, input int n, input logic [63:0] data);
    brf_in_t req;
    int      gap;
    req.command     = cmd;
    req.byte_count  = 4'(n);
    req.write_bytes = data;
    gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    // busy is read before the edge settles, so this is the accepting edge
    do @(posedge clk); while (busy);
    replies_due.push_back(apply_ring_command(req));
  endtask

  task automatic wait_for_replies();
    release_start();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // empty ring, zero lengths, over-long counts, spare codes and clear
  task automatic test_corner_commands();
    issue_command(CMD_READ, 1, '0);
    issue_command(CMD_PEEK, 1, '0);
    issue_command(CMD_DROP, 1, '0);
    issue_command(CMD_WRITE, 0, random_word());
    issue_command(CMD_READ, 0, '0);
    issue_command(CMD_PEEK, 0, '0);
    issue_command(CMD_DROP, 0, '0);
    issue_command(CMD_WRITE, XFER_LIMIT, '1);
    issue_command(CMD_PEEK, XFER_LIMIT, '0);
    issue_command(CMD_READ, XFER_LIMIT, '0);
    issue_command(CMD_WRITE, XFER_LIMIT, '0);
    issue_command(CMD_WRITE, 15, '1);
    issue_command(CMD_READ, 9, '0);
    issue_command(CMD_PEEK, 12, '0);
    issue_command(CMD_DROP, 15, '0);
    issue_command(CMD_WRITE, 3, random_word());
    issue_command(CMD_PEEK, 3, '1);
    issue_command(CMD_DROP, 2, '0);
    issue_command(CMD_READ, 1, '0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) issue_command(3'(c), 1, '1);
    issue_command(CMD_CLEAR, 15, '1);
    issue_command(CMD_CLEAR, 0, '0);
  endtask

  // fill to the brim, overflow, then walk both pointers past the wrap point
  task automatic test_fill_and_wrap();
    int n;
    issue_command(CMD_CLEAR, 0, '0);
    while (ring_level < RING_DEPTH) begin
      n = $urandom_range(1, XFER_LIMIT);
      if (int'(ring_level) + n > RING_DEPTH) n = RING_DEPTH - int'(ring_level);
      issue_command(CMD_WRITE, n, random_word());
    end
    issue_command(CMD_WRITE, 1, random_word());
    issue_command(CMD_WRITE, XFER_LIMIT, random_word());
    issue_command(CMD_WRITE, 0, random_word());
    issue_command(CMD_PEEK, XFER_LIMIT, '0);
    for (int k = 0; k < 40; k++) begin
      issue_command(CMD_READ, XFER_LIMIT, '0);
      issue_command(CMD_WRITE, $urandom_range(1, XFER_LIMIT), random_word());
    end
    while (ring_level != 0) begin
      n = (ring_level < XFER_LIMIT) ? int'(ring_level) : XFER_LIMIT;
      issue_command(($urandom_range(0, 3) == 0) ? CMD_DROP : CMD_READ, n, '0);
    end
    issue_command(CMD_READ, 1, '0);
  endtask

  // sender holds back until every reply is in, then carries on
  task automatic test_pause_until_drained();
    issue_command(CMD_WRITE, 5, random_word());
    issue_command(CMD_WRITE, 6, random_word());
    wait_for_replies();
    issue_command(CMD_PEEK, 7, '0);
    issue_command(CMD_READ, 11 - 7, '0);
  endtask

  // mostly well-formed traffic that swings the level between empty and full
  task automatic test_random_traffic();
    logic        filling;
    int          pick;
    int          n;
    logic [2:0]  cmd;
    filling = 1'b1;
    for (int k = 0; k < RANDOM_CMDS; k++) begin
      if (k % 50 == 0) gap_ceiling = (gap_ceiling == 0) ? MAX_GAP : 0;
      if (k % 90 == 89) wait_for_replies();
      if (ring_level >= RING_DEPTH - 8) filling = 1'b0;
      else if (ring_level <= 8) filling = 1'b1;
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, XFER_LIMIT);
      if (filling) begin
        if (pick < 60) cmd = CMD_WRITE;
        else if (pick < 75) cmd = CMD_READ;
        else if (pick < 85) cmd = CMD_PEEK;
        else if (pick < 92) cmd = CMD_DROP;
        else if (pick < 94) cmd = CMD_CLEAR;
        else if (pick < 97) cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else begin
          cmd = 3'($urandom_range(0, 7));
          n   = $urandom_range(XFER_LIMIT + 1, 15);
        end
      end else begin
        if (pick < 25) cmd = CMD_WRITE;
        else if (pick < 55) cmd = CMD_READ;
        else if (pick < 70) cmd = CMD_PEEK;
        else if (pick < 85) cmd = CMD_DROP;
        else if (pick < 87) cmd = CMD_CLEAR;
        else if (pick < 92) cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else begin
          cmd = 3'($urandom_range(0, 7));
          n   = $urandom_range(XFER_LIMIT + 1, 15);
        end
      end
      issue_command(cmd, n, random_word());
    end
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // every done cycle is one reply transfer, matched against the oldest owed
  always @(posedge clk) begin
    brf_out_t want;
    if (!rst && done) begin
      if (replies_due.size() == 0) begin
        error_count++;
        $display("%0t: reply with none owed, expected nothing, actual %h", $time, result);
      end else begin
        want = replies_due.pop_front();
        report_field("ok", 64'(want.ok), 64'(result.ok));
        report_field("read_bytes", want.read_bytes, result.read_bytes);
        report_field("fill_level", 64'(want.fill_level), 64'(result.fill_level));
        report_field("is_empty", 64'(want.is_empty), 64'(result.is_empty));
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    error_count = 0;
    gap_ceiling = MAX_GAP;
    ring_rd_ptr = '0;
    ring_wr_ptr = '0;
    ring_level  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_corner_commands();
    test_pause_until_drained();
    test_fill_and_wrap();
    test_random_traffic();

    wait_for_replies();
    // a little slack so that any stray reply shows up
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // guard against a hang: well above the slowest legal run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/brf_pkg.sv
design/brf_ram.sv
design/brf_ctrl.sv
design/brf_dp.sv
design/byte_ring_fifo_multi_byte.sv
sim/byte_ring_fifo_multi_byte_test.sv
